/* rtl/lkec_pkg.sv */
`default_nettype none
package lkec_pkg;

    localparam int MAX_LIST  = 16;
    localparam int RANK_W    = 4;
    localparam int CNT_W     = 32;
    localparam int KEY_W     = 32;
    localparam int STATUS_W  = 3;
    localparam int SLOT_W    = 4;
    localparam int CAP_W     = 5;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 5;

    localparam logic [1:0] CMD_GET   = 2'd0;
    localparam logic [1:0] CMD_QUERY = 2'd1;
    localparam logic [1:0] CMD_LIST  = 2'd2;
    localparam logic [1:0] CMD_NONE  = 2'd3;

    localparam logic [STATUS_W-1:0] STAT_HIT        = 3'd0;
    localparam logic [STATUS_W-1:0] STAT_MISS       = 3'd1;
    localparam logic [STATUS_W-1:0] STAT_INVALID    = 3'd2;
    localparam logic [STATUS_W-1:0] STAT_DISABLED   = 3'd3;
    localparam logic [STATUS_W-1:0] STAT_LIST_ENTRY = 3'd4;
    localparam logic [STATUS_W-1:0] STAT_LIST_EMPTY = 3'd5;

    localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ENABLED  = 2'd1;

    localparam logic [CAP_W-1:0] CAPACITY_RESET = 5'd2;
    localparam logic [CNT_W-1:0] CNT_MAX        = 32'hFFFF_FFFF;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_UPDATE,
        ST_ORDER,
        ST_WALK_RD,
        ST_WALK_DATA,
        ST_RESP
    } state_t;

endpackage
`default_nettype wire

/* rtl/lkec_ram.sv */
`default_nettype none
module lkec_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  wire logic                                  clk,
    input  wire logic                                  we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                      wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

/* rtl/lru_keyed_entry_cache_unit.sv */
`default_nettype none
// Get and query: an enabled, valid request runs the one-slot-per-cycle tag scan
// through the key RAM and its registered read, then the UPDATE and RESP states.
// List: ORDER builds the recency order; keys then pass WALK_RD, WALK_DATA and RESP.
// A new item is taken once the last result of the previous one is registered.
// Reset clears all valid bits, occupancy and counters at once; capacity resets to 2
// and the block starts disabled. Writing capacity empties the store.
module lru_keyed_entry_cache_unit #(
    parameter int SLOTS = 16
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 in_valid,
    output logic                                      in_ready,
    input  wire logic [1:0]                           cmd,
    input  wire logic signed [lkec_pkg::KEY_W-1:0]    domain_id,
    input  wire logic signed [lkec_pkg::KEY_W-1:0]    time_step,
    output logic                                      out_valid,
    input  wire logic                                 out_ready,
    output logic [lkec_pkg::STATUS_W-1:0]             status,
    output logic [lkec_pkg::SLOT_W-1:0]               slot,
    output logic                                      present,
    output logic                                      evicted,
    output logic signed [lkec_pkg::KEY_W-1:0]         evicted_domain,
    output logic signed [lkec_pkg::KEY_W-1:0]         evicted_time,
    output logic signed [lkec_pkg::KEY_W-1:0]         entry_domain,
    output logic signed [lkec_pkg::KEY_W-1:0]         entry_time,
    output logic [lkec_pkg::CNT_W-1:0]                loads_total,
    output logic [lkec_pkg::CNT_W-1:0]                purges_total,
    output logic                                      last,
    input  wire logic                                 cfg_valid,
    output logic                                      cfg_ready,
    input  wire logic [lkec_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [lkec_pkg::CFG_DAT_W-1:0]       cfg_data
);

    localparam int IW      = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW      = $clog2(SLOTS + 1);
    localparam int CAP_MAX = (SLOTS < lkec_pkg::MAX_LIST) ? SLOTS : lkec_pkg::MAX_LIST;
    localparam int KW      = lkec_pkg::KEY_W;
    localparam int RW      = lkec_pkg::RANK_W;

    lkec_pkg::state_t state_reg, state_next;

    logic [lkec_pkg::CAP_W-1:0] capacity_reg, capacity_next;
    logic                       enabled_reg, enabled_next;
    logic [lkec_pkg::CAP_W-1:0] occupancy_reg, occupancy_next;
    logic [lkec_pkg::CNT_W-1:0] load_cnt_reg, load_cnt_next;
    logic [lkec_pkg::CNT_W-1:0] purge_cnt_reg, purge_cnt_next;
    logic                       valid_reg [SLOTS];
    logic                       valid_next [SLOTS];
    logic [RW-1:0]              rank_reg [SLOTS];
    logic [RW-1:0]              rank_next [SLOTS];
    logic [IW-1:0]              order_reg [lkec_pkg::MAX_LIST];
    logic [IW-1:0]              order_next [lkec_pkg::MAX_LIST];

    logic [1:0]                 cmd_reg, cmd_next;
    logic [KW-1:0]              key_dom_reg, key_dom_next;
    logic [KW-1:0]              key_time_reg, key_time_next;

    logic [CW-1:0]              scan_idx_reg, scan_idx_next;
    logic                       cmp_vld_reg, cmp_vld_next;
    logic [IW-1:0]              cmp_idx_reg, cmp_idx_next;
    logic [lkec_pkg::CAP_W-1:0] walk_r_reg, walk_r_next;

    logic                       hit_reg, hit_next;
    logic [IW-1:0]              hit_slot_reg, hit_slot_next;
    logic [RW-1:0]              hit_rank_reg, hit_rank_next;
    logic                       free_found_reg, free_found_next;
    logic [IW-1:0]              free_slot_reg, free_slot_next;
    logic [IW-1:0]              lru_slot_reg, lru_slot_next;
    logic [KW-1:0]              lru_dom_reg, lru_dom_next;
    logic [KW-1:0]              lru_time_reg, lru_time_next;

    logic [lkec_pkg::STATUS_W-1:0] res_status_reg, res_status_next;
    logic [lkec_pkg::SLOT_W-1:0]   res_slot_reg, res_slot_next;
    logic                          res_present_reg, res_present_next;
    logic                          res_evicted_reg, res_evicted_next;
    logic [KW-1:0]                 res_ev_dom_reg, res_ev_dom_next;
    logic [KW-1:0]                 res_ev_time_reg, res_ev_time_next;
    logic [KW-1:0]                 res_ent_dom_reg, res_ent_dom_next;
    logic [KW-1:0]                 res_ent_time_reg, res_ent_time_next;
    logic                          res_last_reg, res_last_next;

    logic                          out_valid_reg, out_valid_next;
    logic [lkec_pkg::STATUS_W-1:0] out_status_reg, out_status_next;
    logic [lkec_pkg::SLOT_W-1:0]   out_slot_reg, out_slot_next;
    logic                          out_present_reg, out_present_next;
    logic                          out_evicted_reg, out_evicted_next;
    logic [KW-1:0]                 out_ev_dom_reg, out_ev_dom_next;
    logic [KW-1:0]                 out_ev_time_reg, out_ev_time_next;
    logic [KW-1:0]                 out_ent_dom_reg, out_ent_dom_next;
    logic [KW-1:0]                 out_ent_time_reg, out_ent_time_next;
    logic [lkec_pkg::CNT_W-1:0]    out_loads_reg, out_loads_next;
    logic [lkec_pkg::CNT_W-1:0]    out_purges_reg, out_purges_next;
    logic                          out_last_reg, out_last_next;

    logic                       ram_we;
    logic [IW-1:0]              ram_waddr;
    logic [2*KW-1:0]            ram_wdata;
    logic [IW-1:0]              ram_raddr;
    logic [2*KW-1:0]            ram_rdata;

    logic [lkec_pkg::CAP_W-1:0] eff_cap;
    logic                       full;
    logic [IW-1:0]              ins_slot;
    logic                       in_acc;
    logic                       out_free;
    logic                       cmp_valid;
    logic [RW-1:0]              cmp_rank;

    lkec_ram #(
        .WIDTH (2 * KW),
        .DEPTH (SLOTS)
    ) u_key_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        if (capacity_reg == '0)
        begin
            eff_cap = lkec_pkg::CAP_W'(1);
        end
        else if (capacity_reg > lkec_pkg::CAP_W'(CAP_MAX))
        begin
            eff_cap = lkec_pkg::CAP_W'(CAP_MAX);
        end
        else
        begin
            eff_cap = capacity_reg;
        end
    end

    assign full      = (occupancy_reg >= eff_cap);
    assign ins_slot  = full ? lru_slot_reg : free_slot_reg;
    assign in_ready  = (state_reg == lkec_pkg::ST_IDLE);
    assign in_acc    = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;
    assign cfg_ready = 1'b1;
    assign cmp_valid = valid_reg[cmp_idx_reg];
    assign cmp_rank  = rank_reg[cmp_idx_reg];

    assign ram_we    = (state_reg == lkec_pkg::ST_UPDATE) && (cmd_reg == lkec_pkg::CMD_GET)
                       && !hit_reg;
    assign ram_waddr = ins_slot;
    assign ram_wdata = {key_dom_reg, key_time_reg};

    always_comb
    begin
        if (state_reg == lkec_pkg::ST_WALK_RD)
        begin
            ram_raddr = order_reg[walk_r_reg[RW-1:0]];
        end
        else
        begin
            ram_raddr = scan_idx_reg[IW-1:0];
        end
    end

    always_comb
    begin
        state_next        = state_reg;
        capacity_next     = capacity_reg;
        enabled_next      = enabled_reg;
        occupancy_next    = occupancy_reg;
        load_cnt_next     = load_cnt_reg;
        purge_cnt_next    = purge_cnt_reg;
        valid_next        = valid_reg;
        rank_next         = rank_reg;
        order_next        = order_reg;
        cmd_next          = cmd_reg;
        key_dom_next      = key_dom_reg;
        key_time_next     = key_time_reg;
        scan_idx_next     = scan_idx_reg;
        cmp_vld_next      = 1'b0;
        cmp_idx_next      = cmp_idx_reg;
        walk_r_next       = walk_r_reg;
        hit_next          = hit_reg;
        hit_slot_next     = hit_slot_reg;
        hit_rank_next     = hit_rank_reg;
        free_found_next   = free_found_reg;
        free_slot_next    = free_slot_reg;
        lru_slot_next     = lru_slot_reg;
        lru_dom_next      = lru_dom_reg;
        lru_time_next     = lru_time_reg;
        res_status_next   = res_status_reg;
        res_slot_next     = res_slot_reg;
        res_present_next  = res_present_reg;
        res_evicted_next  = res_evicted_reg;
        res_ev_dom_next   = res_ev_dom_reg;
        res_ev_time_next  = res_ev_time_reg;
        res_ent_dom_next  = res_ent_dom_reg;
        res_ent_time_next = res_ent_time_reg;
        res_last_next     = res_last_reg;
        out_valid_next    = out_valid_reg && !out_ready;
        out_status_next   = out_status_reg;
        out_slot_next     = out_slot_reg;
        out_present_next  = out_present_reg;
        out_evicted_next  = out_evicted_reg;
        out_ev_dom_next   = out_ev_dom_reg;
        out_ev_time_next  = out_ev_time_reg;
        out_ent_dom_next  = out_ent_dom_reg;
        out_ent_time_next = out_ent_time_reg;
        out_loads_next    = out_loads_reg;
        out_purges_next   = out_purges_reg;
        out_last_next     = out_last_reg;

        unique case (state_reg)
            lkec_pkg::ST_IDLE:
            begin
                if (in_acc)
                begin
                    cmd_next          = cmd;
                    key_dom_next      = domain_id;
                    key_time_next     = time_step;
                    scan_idx_next     = '0;
                    walk_r_next       = '0;
                    hit_next          = 1'b0;
                    free_found_next   = 1'b0;
                    free_slot_next    = '0;
                    lru_slot_next     = '0;
                    lru_dom_next      = '0;
                    lru_time_next     = '0;
                    res_status_next   = lkec_pkg::STAT_HIT;
                    res_slot_next     = '0;
                    res_present_next  = 1'b0;
                    res_evicted_next  = 1'b0;
                    res_ev_dom_next   = '0;
                    res_ev_time_next  = '0;
                    res_ent_dom_next  = '0;
                    res_ent_time_next = '0;
                    res_last_next     = 1'b1;
                    unique case (cmd) inside
                        lkec_pkg::CMD_NONE:
                        begin
                            state_next = lkec_pkg::ST_IDLE;
                        end
                        lkec_pkg::CMD_LIST:
                        begin
                            if (!enabled_reg)
                            begin
                                res_status_next = lkec_pkg::STAT_DISABLED;
                                state_next      = lkec_pkg::ST_RESP;
                            end
                            else if (occupancy_reg == '0)
                            begin
                                res_status_next = lkec_pkg::STAT_LIST_EMPTY;
                                state_next      = lkec_pkg::ST_RESP;
                            end
                            else
                            begin
                                state_next = lkec_pkg::ST_ORDER;
                            end
                        end
                        lkec_pkg::CMD_GET, lkec_pkg::CMD_QUERY:
                        begin
                            if (!enabled_reg)
                            begin
                                res_status_next = lkec_pkg::STAT_DISABLED;
                                state_next      = lkec_pkg::ST_RESP;
                            end
                            else if (domain_id[KW-1])
                            begin
                                res_status_next = lkec_pkg::STAT_INVALID;
                                state_next      = lkec_pkg::ST_RESP;
                            end
                            else
                            begin
                                state_next = lkec_pkg::ST_SCAN;
                            end
                        end
                        default:
                        begin
                            state_next = lkec_pkg::ST_IDLE;
                        end
                    endcase
                end
            end

            lkec_pkg::ST_SCAN:
            begin
                if (scan_idx_reg < CW'(SLOTS))
                begin
                    cmp_vld_next  = 1'b1;
                    cmp_idx_next  = scan_idx_reg[IW-1:0];
                    scan_idx_next = scan_idx_reg + CW'(1);
                end
                else if (!cmp_vld_reg)
                begin
                    state_next = lkec_pkg::ST_UPDATE;
                end
                if (cmp_vld_reg)
                begin
                    if (cmp_valid && !hit_reg && ram_rdata == {key_dom_reg, key_time_reg})
                    begin
                        hit_next      = 1'b1;
                        hit_slot_next = cmp_idx_reg;
                        hit_rank_next = cmp_rank;
                    end
                    if (!cmp_valid && !free_found_reg)
                    begin
                        free_found_next = 1'b1;
                        free_slot_next  = cmp_idx_reg;
                    end
                    if (cmp_valid
                        && (lkec_pkg::CAP_W'(cmp_rank) + lkec_pkg::CAP_W'(1) == occupancy_reg))
                    begin
                        lru_slot_next = cmp_idx_reg;
                        lru_dom_next  = ram_rdata[2*KW-1:KW];
                        lru_time_next = ram_rdata[KW-1:0];
                    end
                end
            end

            lkec_pkg::ST_UPDATE:
            begin
                state_next = lkec_pkg::ST_RESP;
                if (cmd_reg == lkec_pkg::CMD_QUERY)
                begin
                    res_status_next  = lkec_pkg::STAT_HIT;
                    res_present_next = hit_reg;
                    res_slot_next    = hit_reg ? lkec_pkg::SLOT_W'(hit_slot_reg) : '0;
                end
                else if (hit_reg)
                begin
                    for (int i = 0; i < SLOTS; i++)
                    begin
                        if (valid_reg[i] && rank_reg[i] < hit_rank_reg)
                        begin
                            rank_next[i] = rank_reg[i] + RW'(1);
                        end
                    end
                    rank_next[hit_slot_reg] = '0;
                    res_status_next = lkec_pkg::STAT_HIT;
                    res_slot_next   = lkec_pkg::SLOT_W'(hit_slot_reg);
                end
                else
                begin
                    for (int i = 0; i < SLOTS; i++)
                    begin
                        if (valid_reg[i])
                        begin
                            rank_next[i] = rank_reg[i] + RW'(1);
                        end
                    end
                    rank_next[ins_slot]  = '0;
                    valid_next[ins_slot] = 1'b1;
                    if (full)
                    begin
                        res_evicted_next = 1'b1;
                        res_ev_dom_next  = lru_dom_reg;
                        res_ev_time_next = lru_time_reg;
                        if (purge_cnt_reg != lkec_pkg::CNT_MAX)
                        begin
                            purge_cnt_next = purge_cnt_reg + lkec_pkg::CNT_W'(1);
                        end
                    end
                    else
                    begin
                        occupancy_next = occupancy_reg + lkec_pkg::CAP_W'(1);
                    end
                    if (load_cnt_reg != lkec_pkg::CNT_MAX)
                    begin
                        load_cnt_next = load_cnt_reg + lkec_pkg::CNT_W'(1);
                    end
                    res_status_next = lkec_pkg::STAT_MISS;
                    res_slot_next   = lkec_pkg::SLOT_W'(ins_slot);
                end
            end

            lkec_pkg::ST_ORDER:
            begin
                if (scan_idx_reg < CW'(SLOTS))
                begin
                    if (valid_reg[scan_idx_reg[IW-1:0]])
                    begin
                        order_next[rank_reg[scan_idx_reg[IW-1:0]]] = scan_idx_reg[IW-1:0];
                    end
                    scan_idx_next = scan_idx_reg + CW'(1);
                end
                else
                begin
                    state_next = lkec_pkg::ST_WALK_RD;
                end
            end

            lkec_pkg::ST_WALK_RD:
            begin
                state_next = lkec_pkg::ST_WALK_DATA;
            end

            lkec_pkg::ST_WALK_DATA:
            begin
                res_status_next   = lkec_pkg::STAT_LIST_ENTRY;
                res_ent_dom_next  = ram_rdata[2*KW-1:KW];
                res_ent_time_next = ram_rdata[KW-1:0];
                res_last_next     = (walk_r_reg + lkec_pkg::CAP_W'(1) == occupancy_reg);
                walk_r_next       = walk_r_reg + lkec_pkg::CAP_W'(1);
                state_next        = lkec_pkg::ST_RESP;
            end

            lkec_pkg::ST_RESP:
            begin
                if (out_free)
                begin
                    out_valid_next    = 1'b1;
                    out_status_next   = res_status_reg;
                    out_slot_next     = res_slot_reg;
                    out_present_next  = res_present_reg;
                    out_evicted_next  = res_evicted_reg;
                    out_ev_dom_next   = res_ev_dom_reg;
                    out_ev_time_next  = res_ev_time_reg;
                    out_ent_dom_next  = res_ent_dom_reg;
                    out_ent_time_next = res_ent_time_reg;
                    out_loads_next    = load_cnt_reg;
                    out_purges_next   = purge_cnt_reg;
                    out_last_next     = res_last_reg;
                    state_next        = res_last_reg ? lkec_pkg::ST_IDLE : lkec_pkg::ST_WALK_RD;
                end
            end

            default:
            begin
                state_next = lkec_pkg::ST_IDLE;
            end
        endcase

        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                lkec_pkg::CFG_CAPACITY:
                begin
                    capacity_next  = cfg_data;
                    occupancy_next = '0;
                    for (int i = 0; i < SLOTS; i++)
                    begin
                        valid_next[i] = 1'b0;
                    end
                end
                lkec_pkg::CFG_ENABLED:
                begin
                    enabled_next = cfg_data[0];
                end
                default:
                begin
                    enabled_next = enabled_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lkec_pkg::ST_IDLE;
            capacity_reg  <= lkec_pkg::CAPACITY_RESET;
            enabled_reg   <= 1'b0;
            occupancy_reg <= '0;
            load_cnt_reg  <= '0;
            purge_cnt_reg <= '0;
            cmp_vld_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < SLOTS; i++)
            begin
                valid_reg[i] <= 1'b0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            capacity_reg  <= capacity_next;
            enabled_reg   <= enabled_next;
            occupancy_reg <= occupancy_next;
            load_cnt_reg  <= load_cnt_next;
            purge_cnt_reg <= purge_cnt_next;
            cmp_vld_reg   <= cmp_vld_next;
            out_valid_reg <= out_valid_next;
            valid_reg     <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rank_reg         <= rank_next;
        order_reg        <= order_next;
        cmd_reg          <= cmd_next;
        key_dom_reg      <= key_dom_next;
        key_time_reg     <= key_time_next;
        scan_idx_reg     <= scan_idx_next;
        cmp_idx_reg      <= cmp_idx_next;
        walk_r_reg       <= walk_r_next;
        hit_reg          <= hit_next;
        hit_slot_reg     <= hit_slot_next;
        hit_rank_reg     <= hit_rank_next;
        free_found_reg   <= free_found_next;
        free_slot_reg    <= free_slot_next;
        lru_slot_reg     <= lru_slot_next;
        lru_dom_reg      <= lru_dom_next;
        lru_time_reg     <= lru_time_next;
        res_status_reg   <= res_status_next;
        res_slot_reg     <= res_slot_next;
        res_present_reg  <= res_present_next;
        res_evicted_reg  <= res_evicted_next;
        res_ev_dom_reg   <= res_ev_dom_next;
        res_ev_time_reg  <= res_ev_time_next;
        res_ent_dom_reg  <= res_ent_dom_next;
        res_ent_time_reg <= res_ent_time_next;
        res_last_reg     <= res_last_next;
        out_status_reg   <= out_status_next;
        out_slot_reg     <= out_slot_next;
        out_present_reg  <= out_present_next;
        out_evicted_reg  <= out_evicted_next;
        out_ev_dom_reg   <= out_ev_dom_next;
        out_ev_time_reg  <= out_ev_time_next;
        out_ent_dom_reg  <= out_ent_dom_next;
        out_ent_time_reg <= out_ent_time_next;
        out_loads_reg    <= out_loads_next;
        out_purges_reg   <= out_purges_next;
        out_last_reg     <= out_last_next;
    end

    assign out_valid      = out_valid_reg;
    assign status         = out_status_reg;
    assign slot           = out_slot_reg;
    assign present        = out_present_reg;
    assign evicted        = out_evicted_reg;
    assign evicted_domain = $signed(out_ev_dom_reg);
    assign evicted_time   = $signed(out_ev_time_reg);
    assign entry_domain   = $signed(out_ent_dom_reg);
    assign entry_time     = $signed(out_ent_time_reg);
    assign loads_total    = out_loads_reg;
    assign purges_total   = out_purges_reg;
    assign last           = out_last_reg;

endmodule
`default_nettype wire
